// ----- hdl/ubd_pkg.sv -----
package ubd_pkg;

    // Fixed field and register widths.
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int SYM_W      = 8;
    localparam int POS_W      = 6;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CHUNK_BITS = 8;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LENGTH  = 2'd0,
        CFG_SYMBOLS_LOW  = 2'd1,
        CFG_SYMBOLS_HIGH = 2'd2
    } cfg_index_t;

    // Register values after reset: radix ten, symbols "0123456789".
    localparam logic [RADIX_W-1:0] BASE_LENGTH_RESET  = 5'd10;
    localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RESET  = 64'd3978425819141910832;
    localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RESET = 64'd14648;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOAD
    } state_t;

    // Command to the divider.
    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] radix;
    } div_ctrl_t;

    // Status back from the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hdl/ubd_divider.sv -----
module ubd_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ubd_pkg::div_ctrl_t          ctrl,
    input  logic [VALUE_BITS-1:0]       dividend,
    output ubd_pkg::div_status_t        status,
    output logic [VALUE_BITS-1:0]       quotient,
    output logic [ubd_pkg::DIGIT_W-1:0] remainder
);
    import ubd_pkg::*;

    localparam int DIV_STEPS = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_BITS  = DIV_STEPS * CHUNK_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    logic [PAD_BITS-1:0]   quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CHUNK_BITS-1:0] chunk_q;
    logic [DIGIT_W-1:0]    chunk_r;

    // One chunk of restoring division: eight compare-subtract steps on a
    // remainder that always stays below the radix.
    always_comb begin
        logic [DIGIT_W:0] trial;
        chunk_r = rem_reg;
        chunk_q = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            trial = {chunk_r, quo_reg[PAD_BITS-1-i]};
            if (trial >= radix_reg) begin
                trial = trial - radix_reg;
                chunk_q[CHUNK_BITS-1-i] = 1'b1;
            end
            chunk_r = trial[DIGIT_W-1:0];
        end
    end

    // Load on start, then shift one chunk of quotient bits in per cycle.
    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctrl.start && !busy_reg) begin
            quo_next   = PAD_BITS'(dividend);
            rem_next   = '0;
            radix_next = ctrl.radix;
            step_next  = STEP_W'(DIV_STEPS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            quo_next  = (quo_reg << CHUNK_BITS) | PAD_BITS'(chunk_q);
            rem_next  = chunk_r;
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg[VALUE_BITS-1:0];
    assign remainder   = rem_reg;

endmodule

// ----- hdl/ubd_digit_stack.sv -----
module ubd_digit_stack #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/unsigned_to_base_digits_unit.sv -----
// Unsigned value to digit characters in a programmable radix.
//
// The input channel (s_valid, s_ready, s_value) takes one value. The result
// channel (m_valid, m_ready) then delivers one beat per digit, most significant
// first: m_character is the table symbol, m_position the one-based index and
// m_last marks the least significant digit, where m_position is the count.
// Zero gives a single beat. Users must write registers via cfg_wr_en, cfg_index
// and cfg_wr_data only while no value is in flight; the block does not check.
//
// Each digit takes one pass through the divider, which retires eight quotient
// bits per cycle. Once all digits are stacked, each is read back into the
// output register through ST_READ and ST_LOAD; ST_LOAD waits while the output
// register still holds an untaken beat. s_ready is high only between values.
//
// Reset clears the sequencer and the output valid and restores radix ten with
// the symbols 0 to 9. A stalled receiver holds the current beat in the output
// register; the block waits and drops nothing. The last beat may still wait
// there while the next value is accepted.
module unsigned_to_base_digits_unit #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_BASE   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ubd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ubd_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_BITS-1:0]         s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ubd_pkg::SYM_W-1:0]     m_character,
    output logic [ubd_pkg::POS_W-1:0]     m_position,
    output logic                          m_last
);
    import ubd_pkg::*;

    localparam int ADDR_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    logic [RADIX_W-1:0]    base_length_reg;
    logic [CFG_W-1:0]      symbols_low_reg;
    logic [CFG_W-1:0]      symbols_high_reg;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]      character_reg, character_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic                  last_reg, last_next;

    logic [RADIX_W-1:0]    radix_eff;
    div_ctrl_t             div_ctrl;
    div_status_t           div_status;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;
    logic                  push_en;
    logic                  rd_en;
    logic [DIGIT_W-1:0]    rd_digit;
    logic [CNT_W-1:0]      count_inc;
    logic [2*CFG_W-1:0]    sym_table;
    logic                  out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_length_reg  <= BASE_LENGTH_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BASE_LENGTH:  base_length_reg  <= cfg_wr_data[RADIX_W-1:0];
                CFG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_wr_data;
                CFG_SYMBOLS_HIGH: symbols_high_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Radix clamped to the range the table supports.
    always_comb begin
        if (base_length_reg < RADIX_W'(2)) begin
            radix_eff = RADIX_W'(2);
        end else if (base_length_reg > RADIX_W'(MAX_BASE)) begin
            radix_eff = RADIX_W'(MAX_BASE);
        end else begin
            radix_eff = base_length_reg;
        end
    end

    ubd_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    ubd_digit_stack #(
        .DEPTH  (VALUE_BITS),
        .ADDR_W (ADDR_W),
        .DATA_W (DIGIT_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (push_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (div_remainder),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_digit)
    );

    assign count_inc = count_reg + 1'b1;
    assign sym_table = {symbols_high_reg, symbols_low_reg};
    assign out_free  = !m_valid_reg || m_ready;

    // Sequencer: divide until the quotient is zero or the stack is full, then pop the digits.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        character_next = character_reg;
        position_next  = position_reg;
        last_next      = last_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.radix = radix_eff;
        div_dividend   = div_quotient;
        push_en        = 1'b0;
        rd_en          = 1'b0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                div_dividend = s_value;
                if (s_valid) begin
                    div_ctrl.start = 1'b1;
                    count_next     = '0;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    push_en    = 1'b1;
                    count_next = count_inc;
                    if (div_quotient == '0 || count_inc == CNT_W'(VALUE_BITS)) begin
                        ptr_next   = count_reg[ADDR_W-1:0];
                        state_next = ST_READ;
                    end else begin
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    character_next = sym_table[{rd_digit, 3'b000} +: SYM_W];
                    position_next  = POS_W'(count_reg - CNT_W'(ptr_reg));
                    last_next      = (ptr_reg == '0);
                    if (ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
        character_reg <= character_next;
        position_reg  <= position_next;
        last_reg      <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = character_reg;
    assign m_position  = position_reg;
    assign m_last      = last_reg;

endmodule

// ----- hdl/ubd_checker.sv -----
module ubd_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [ubd_pkg::SYM_W-1:0] m_character,
    input logic [ubd_pkg::POS_W-1:0] m_position,
    input logic                      m_last
);
    import ubd_pkg::*;

    // A stalled beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) &&
            $stable(m_position) && $stable(m_last))
        else $error("result beat changed while stalled");

    // An accepted value keeps the block busy for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a value");

    // Only the final beat of a run may still be pending when input is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_last)
        else $error("input open while a run is still being emitted");

    // A beat that directly follows the end of a run opens the next run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || m_position == POS_W'(1))
        else $error("beat after the end of a run is not at position one");

endmodule

bind unsigned_to_base_digits_unit ubd_checker u_ubd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_position  (m_position),
    .m_last      (m_last)
);
